// ===== hw/rtl/button_gesture_classifier_core_defines.svh =====
// ----------------------------------------------------------------------------
// Button gesture classifier assertion macros
// Concurrent assertion wrappers used by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_CORE_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define BGC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bgc assertion failed");
`define BGC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bgc assertion failed");
`else
`define BGC_ASSERT(label, clk, rst, prop)
`define BGC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Request and result types, state codes and register constants.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int TICK_COUNT_WIDTH_DEF = 16;
  localparam int CFG_DATA_W           = 16;
  localparam int CFG_IDX_W            = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN     = 2'd2;

  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST  = 16'd25;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_TAP_RST  = 16'd15;
  localparam logic [CFG_DATA_W-1:0] SHUTDOWN_RST    = 16'd75;

  typedef enum logic [2:0] {
    MODE_IDLE        = 3'd0,
    MODE_PRESSED     = 3'd1,
    MODE_WAIT_DOUBLE = 3'd2,
    MODE_LONG_HOLD   = 3'd3,
    MODE_SECOND      = 3'd4
  } mode_t;

  typedef struct packed {
    logic pressed;
    logic force_idle;
  } in_t;

  typedef struct packed {
    logic [2:0] gesture_state;
    logic       long_press;
    logic       led_enabled;
    logic       double_tap;
    logic       shutdown_request;
    logic       hold_active;
  } out_t;

endpackage

// ===== hw/rtl/button_gesture_classifier_core.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier core
// Classifies polled button levels into long press, double tap and shutdown
// hold gestures with a five-state machine and a saturating tick counter.
//
//   channel   signals                       direction
//   in        in_valid in_ready in_data     request in, one polling tick
//   out       out_valid out_ready out_data  result out, one per request
//   cfg       cfg_we cfg_index cfg_data     register write, no wait
//
// One request per cycle while the output is not stalled; each result is registered
// and appears in the cycle after its request is taken. The next-state logic is a
// saturating increment and three threshold compares between the state and output registers.
// Reset clears the machine to idle, the LED enable to on and the thresholds
// to their defaults.
// A stalled result is held in the output register; a new request is taken
// whenever that register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_core_defines.svh"

module button_gesture_classifier_core #(
  parameter int TICK_COUNT_WIDTH = bgc_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bgc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bgc_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import bgc_pkg::*;

  localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_DATA_W) ? TICK_COUNT_WIDTH : CFG_DATA_W;

  logic [CFG_DATA_W-1:0]       long_press_ticks;
  logic [CFG_DATA_W-1:0]       double_tap_window_ticks;
  logic [CFG_DATA_W-1:0]       shutdown_hold_ticks;

  mode_t                       mode;
  mode_t                       mode_next;
  logic [TICK_COUNT_WIDTH-1:0] count;
  logic [TICK_COUNT_WIDTH-1:0] count_next;
  logic [TICK_COUNT_WIDTH-1:0] count_inc;
  logic                        fired;
  logic                        fired_next;
  logic                        led_on;
  logic                        led_next;

  logic                        in_fire;
  logic                        lp_hit;
  logic                        dt_hit;
  logic                        sd_hit;
  logic                        long_press_c;
  logic                        double_tap_c;
  logic                        shutdown_c;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign count_inc = (count == {TICK_COUNT_WIDTH{1'b1}}) ? count
                   : count + TICK_COUNT_WIDTH'(1);

  assign lp_hit = CMP_W'(count_inc) >= CMP_W'(long_press_ticks);
  assign dt_hit = CMP_W'(count_inc) >= CMP_W'(double_tap_window_ticks);
  assign sd_hit = CMP_W'(count_inc) >= CMP_W'(shutdown_hold_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks        <= LONG_PRESS_RST;
      double_tap_window_ticks <= DOUBLE_TAP_RST;
      shutdown_hold_ticks     <= SHUTDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS: long_press_ticks        <= cfg_data;
        CFG_DOUBLE_TAP: double_tap_window_ticks <= cfg_data;
        CFG_SHUTDOWN:   shutdown_hold_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_next  = mode;
    count_next = count;
    fired_next = fired;
    led_next   = led_on;
    if (in_data.force_idle) begin
      mode_next  = MODE_IDLE;
      count_next = '0;
      fired_next = 1'b0;
    end else begin
      count_next = count_inc;
      unique case (mode)
        MODE_PRESSED: begin
          if (!in_data.pressed) begin
            mode_next  = lp_hit ? MODE_IDLE : MODE_WAIT_DOUBLE;
            count_next = '0;
            fired_next = 1'b0;
          end else if (lp_hit) begin
            led_next   = !led_on;
            mode_next  = MODE_LONG_HOLD;
            count_next = '0;
            fired_next = 1'b0;
          end
        end
        MODE_LONG_HOLD: begin
          if (!in_data.pressed) begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            fired_next = 1'b0;
          end
        end
        MODE_WAIT_DOUBLE: begin
          if (in_data.pressed) begin
            mode_next  = MODE_SECOND;
            count_next = '0;
            fired_next = 1'b0;
          end else if (dt_hit) begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            fired_next = 1'b0;
          end
        end
        MODE_SECOND: begin
          if (!in_data.pressed) begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            fired_next = 1'b0;
          end else if (!fired && sd_hit) begin
            fired_next = 1'b1;
          end
        end
        default: begin
          if (in_data.pressed) begin
            mode_next  = MODE_PRESSED;
            count_next = '0;
            fired_next = 1'b0;
          end
        end
      endcase
    end
  end

  always_comb begin
    long_press_c = 1'b0;
    double_tap_c = 1'b0;
    shutdown_c   = 1'b0;
    if (!in_data.force_idle) begin
      unique case (mode)
        MODE_PRESSED: long_press_c = in_data.pressed && lp_hit;
        MODE_SECOND: begin
          double_tap_c = !in_data.pressed;
          shutdown_c   = in_data.pressed && !fired && sd_hit;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      count  <= '0;
      fired  <= 1'b0;
      led_on <= 1'b1;
    end else if (in_fire) begin
      mode   <= mode_next;
      count  <= count_next;
      fired  <= fired_next;
      led_on <= led_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.gesture_state    <= mode_next;
      out_data.long_press       <= long_press_c;
      out_data.led_enabled      <= led_next;
      out_data.double_tap       <= double_tap_c;
      out_data.shutdown_request <= shutdown_c;
      out_data.hold_active      <= (mode_next == MODE_LONG_HOLD);
    end
  end

  `BGC_ASSERT(a_long_press_toggles_led, clk, rst, in_fire && long_press_c |=> led_on != $past(led_on))
  `BGC_ASSERT(a_force_idle_clears, clk, rst, in_fire && in_data.force_idle |=> mode == MODE_IDLE && count == '0 && !fired)
  `BGC_ASSERT(a_one_pulse, clk, rst, out_valid |-> $countones({out_data.long_press, out_data.double_tap, out_data.shutdown_request}) <= 1)
  `BGC_ASSERT(a_shutdown_in_second, clk, rst, out_valid && out_data.shutdown_request |-> out_data.gesture_state == MODE_SECOND && fired)
  `BGC_ASSERT_ALWAYS(a_empty_takes_request, clk, !out_valid |-> in_ready)

endmodule
